// ----- rtl/text_tilemap_writer_core_defines.svh -----
// assertion macros shared by the tilemap writer rtl
`ifndef TEXT_TILEMAP_WRITER_CORE_DEFINES_SVH
`define TEXT_TILEMAP_WRITER_CORE_DEFINES_SVH

// same-cycle implication
`define TTW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tilemap writer assertion failed");

// next-cycle implication
`define TTW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tilemap writer assertion failed");

`endif

// ----- rtl/ttw_pkg.sv -----
// constants, types and helper functions of the tilemap writer
package ttw_pkg;

    localparam int TILES_PER_ROW = 32;
    localparam int STORE_ENTRIES = 1024;
    localparam int ADDR_W        = $clog2(STORE_ENTRIES);
    localparam int ENTRY_W       = 16;
    localparam int POS_EXT_W     = 9;
    localparam int LIN_W         = POS_EXT_W + $clog2(TILES_PER_ROW) + 1;

    localparam int DEC_DIGITS    = 5;
    localparam int DEC_CNT_W     = $clog2(DEC_DIGITS + 1);
    localparam int HEX_MAX       = 4;

    localparam logic [2:0] FUNC_PUT  = 3'd0;
    localparam logic [2:0] FUNC_SET  = 3'd1;
    localparam logic [2:0] FUNC_FILL = 3'd2;
    localparam logic [2:0] FUNC_DEC  = 3'd3;
    localparam logic [2:0] FUNC_HEX  = 3'd4;
    localparam logic [2:0] FUNC_READ = 3'd5;

    localparam logic [1:0] CFG_FONT_BASE = 2'd0;
    localparam logic [1:0] CFG_PALETTE   = 2'd1;
    localparam logic [1:0] CFG_PRIORITY  = 2'd2;

    localparam logic [7:0] CHAR_LF       = 8'd10;
    localparam logic [7:0] CHAR_CR       = 8'd13;
    localparam logic [7:0] CHAR_PRINT_LO = 8'd32;
    localparam logic [7:0] CHAR_PRINT_HI = 8'd127;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [3:0] NIBBLE_MASK   = 4'h0F;

    localparam logic [7:0] HEX_GLYPHS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef struct packed {
        logic                 done;
        logic [DEC_CNT_W-1:0] count;
    } dec_status_t;

    function automatic logic [ENTRY_W-1:0] make_entry(
        input logic [7:0] code,
        input logic [9:0] font_base,
        input logic [2:0] palette,
        input logic       prio
    );
        logic [9:0] tile;
        tile = font_base;
        if (code >= CHAR_PRINT_LO && code <= CHAR_PRINT_HI)
        begin
            tile = font_base + 10'(code - CHAR_PRINT_LO);
        end
        return {2'b00, prio, palette, tile};
    endfunction

    function automatic logic [ADDR_W-1:0] lin_addr(
        input logic [POS_EXT_W-1:0] r,
        input logic [POS_EXT_W-1:0] c
    );
        logic [LIN_W-1:0] lin;
        lin = LIN_W'(r) * LIN_W'(TILES_PER_ROW) + LIN_W'(c);
        return lin[ADDR_W-1:0];
    endfunction

    function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
        return HEX_GLYPHS[nib & NIBBLE_MASK];
    endfunction

endpackage

// ----- rtl/ttw_ram.sv -----
// generic single-port ram with registered read
module ttw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ttw_dec.sv -----
// decimal digit extractor, one divide by ten per cycle
module ttw_dec (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [15:0]                   number,
    input  logic [ttw_pkg::DEC_CNT_W-1:0] sel,
    output logic [3:0]                    digit,
    output ttw_pkg::dec_status_t          status
);
    import ttw_pkg::*;

    logic [15:0]          v_reg, v_next;
    logic [DEC_CNT_W-1:0] n_reg, n_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [3:0]           buf_reg [DEC_DIGITS];

    logic [32:0] prod;
    logic [15:0] quot;
    logic [15:0] rem_full;
    logic [3:0]  rem;

    // x / 10 as (x * 0xCCCD) >> 19, exact for 16-bit x
    assign prod     = 33'(v_reg) * 33'(17'h0CCCD);
    assign quot     = 16'(prod >> 19);
    assign rem_full = v_reg - 16'({quot, 3'b000}) - 16'({quot, 1'b0});
    assign rem      = rem_full[3:0];

    always_comb
    begin
        v_next    = v_reg;
        n_next    = n_reg;
        run_next  = run_reg;
        done_next = done_reg;
        if (start)
        begin
            v_next    = number;
            n_next    = '0;
            run_next  = 1'b1;
            done_next = 1'b0;
        end
        else if (run_reg)
        begin
            v_next = quot;
            n_next = n_reg + DEC_CNT_W'(1);
            if (quot == 16'd0 || n_reg == DEC_CNT_W'(DEC_DIGITS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            n_reg    <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_reg    <= v_next;
            n_reg    <= n_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_reg && !start)
        begin
            buf_reg[n_reg] <= rem;
        end
    end

    assign digit        = buf_reg[sel];
    assign status.done  = done_reg;
    assign status.count = n_reg;

endmodule

// ----- rtl/text_tilemap_writer_core.sv -----
// top level of the text tilemap writer: command sequencer, cursor and tile store
// One command word is taken when the block is idle and answered by exactly one
// result word. The tile store is a single-port ram, so cells are written one at
// a time: fill rect writes its width * height cells in turn, print hex writes
// one cell per digit (at most 4), and print decimal first divides by ten once
// per digit, then hands the digit count over, then writes the digits.
// A finished result sits in the output register while the next command is taken.
`include "text_tilemap_writer_core_defines.svh"

module text_tilemap_writer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [7:0]  char_code,
    input  logic [7:0]  col,
    input  logic [7:0]  row,
    input  logic [5:0]  rect_width,
    input  logic [5:0]  rect_height,
    input  logic [15:0] number,
    input  logic [3:0]  hex_digits,
    input  logic [9:0]  read_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] read_entry,
    output logic [7:0]  cursor_col,
    output logic [7:0]  cursor_row,
    output logic        changed
);
    import ttw_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_FILL = 6'b000010,
        S_CONV = 6'b000100,
        S_PUT  = 6'b001000,
        S_READ = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [9:0]  font_base_reg, font_base_next;
    logic [2:0]  palette_reg, palette_next;
    logic        prio_reg, prio_next;

    logic [2:0]  func_reg, func_next;
    logic [7:0]  char_reg, char_next;
    logic [7:0]  col_reg, col_next;
    logic [7:0]  row_reg, row_next;
    logic [5:0]  w_reg, w_next;
    logic [5:0]  h_reg, h_next;
    logic [15:0] number_reg, number_next;
    logic [5:0]  rr_reg, rr_next;
    logic [5:0]  cc_reg, cc_next;
    logic [DEC_CNT_W-1:0] put_cnt_reg, put_cnt_next;
    logic        changed_reg, changed_next;
    logic [15:0] rd_reg, rd_next;
    logic [7:0]  cur_col_reg, cur_col_next;
    logic [7:0]  cur_row_reg, cur_row_next;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] read_entry_reg, read_entry_next;
    logic [7:0]  cursor_col_reg, cursor_col_next;
    logic [7:0]  cursor_row_reg, cursor_row_next;
    logic        changed_out_reg, changed_out_next;

    logic              ram_en;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    logic              dec_start;
    logic [3:0]        dec_digit;
    dec_status_t       dec_status;

    logic [7:0]           put_code;
    logic [3:0]           hex_nib;
    logic [DEC_CNT_W-1:0] hex_cnt;
    logic [7:0]           col_inc;

    ttw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_ENTRIES)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    ttw_dec u_dec (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (dec_start),
        .number (number),
        .sel    (put_cnt_reg - DEC_CNT_W'(1)),
        .digit  (dec_digit),
        .status (dec_status)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign hex_cnt   = (hex_digits > 4'(HEX_MAX)) ? DEC_CNT_W'(HEX_MAX)
                                                  : DEC_CNT_W'(hex_digits);
    assign col_inc   = cur_col_reg + 8'd1;

    always_comb
    begin
        unique case (put_cnt_reg)
            DEC_CNT_W'(1): hex_nib = number_reg[3:0];
            DEC_CNT_W'(2): hex_nib = number_reg[7:4];
            DEC_CNT_W'(3): hex_nib = number_reg[11:8];
            default:       hex_nib = number_reg[15:12];
        endcase
        unique case (func_reg)
            FUNC_DEC: put_code = CHAR_ZERO + 8'(dec_digit);
            FUNC_HEX: put_code = hex_glyph(hex_nib);
            default:  put_code = char_reg;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        font_base_next   = font_base_reg;
        palette_next     = palette_reg;
        prio_next        = prio_reg;
        func_next        = func_reg;
        char_next        = char_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        w_next           = w_reg;
        h_next           = h_reg;
        number_next      = number_reg;
        rr_next          = rr_reg;
        cc_next          = cc_reg;
        put_cnt_next     = put_cnt_reg;
        changed_next     = changed_reg;
        rd_next          = rd_reg;
        cur_col_next     = cur_col_reg;
        cur_row_next     = cur_row_reg;
        out_valid_next   = out_valid_reg;
        read_entry_next  = read_entry_reg;
        cursor_col_next  = cursor_col_reg;
        cursor_row_next  = cursor_row_reg;
        changed_out_next = changed_out_reg;
        ram_en           = 1'b0;
        ram_we           = 1'b0;
        ram_addr         = '0;
        ram_wdata        = '0;
        dec_start        = 1'b0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FONT_BASE: font_base_next = cfg_data;
                CFG_PALETTE:   palette_next   = cfg_data[2:0];
                CFG_PRIORITY:  prio_next      = cfg_data[0];
                default:       ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next    = func;
                    char_next    = char_code;
                    col_next     = col;
                    row_next     = row;
                    w_next       = rect_width;
                    h_next       = rect_height;
                    number_next  = number;
                    rr_next      = '0;
                    cc_next      = '0;
                    changed_next = 1'b0;
                    rd_next      = '0;
                    unique case (func)
                        FUNC_PUT:
                        begin
                            put_cnt_next = DEC_CNT_W'(1);
                            state_next   = S_PUT;
                        end
                        FUNC_SET:
                        begin
                            cur_col_next = col;
                            cur_row_next = row;
                            state_next   = S_DONE;
                        end
                        FUNC_FILL:
                        begin
                            if (rect_width == 6'd0 || rect_height == 6'd0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_FILL;
                            end
                        end
                        FUNC_DEC:
                        begin
                            dec_start  = 1'b1;
                            state_next = S_CONV;
                        end
                        FUNC_HEX:
                        begin
                            put_cnt_next = hex_cnt;
                            if (hex_cnt == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_PUT;
                            end
                        end
                        FUNC_READ:
                        begin
                            ram_en     = 1'b1;
                            ram_addr   = ADDR_W'(read_index);
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                ram_en       = 1'b1;
                ram_we       = 1'b1;
                ram_addr     = lin_addr(POS_EXT_W'(row_reg) + POS_EXT_W'(rr_reg),
                                        POS_EXT_W'(col_reg) + POS_EXT_W'(cc_reg));
                ram_wdata    = make_entry(char_reg, font_base_reg, palette_reg, prio_reg);
                changed_next = 1'b1;
                if (6'(cc_reg + 6'd1) == w_reg)
                begin
                    cc_next = '0;
                    if (6'(rr_reg + 6'd1) == h_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rr_next = rr_reg + 6'd1;
                    end
                end
                else
                begin
                    cc_next = cc_reg + 6'd1;
                end
            end
            S_CONV:
            begin
                if (dec_status.done)
                begin
                    put_cnt_next = dec_status.count;
                    state_next   = S_PUT;
                end
            end
            S_PUT:
            begin
                priority if (put_code == CHAR_LF)
                begin
                    cur_col_next = '0;
                    cur_row_next = cur_row_reg + 8'd1;
                end
                else if (put_code == CHAR_CR)
                begin
                    cur_col_next = '0;
                end
                else
                begin
                    ram_en       = 1'b1;
                    ram_we       = 1'b1;
                    ram_addr     = lin_addr(POS_EXT_W'(cur_row_reg), POS_EXT_W'(cur_col_reg));
                    ram_wdata    = make_entry(put_code, font_base_reg, palette_reg, prio_reg);
                    changed_next = 1'b1;
                    if (col_inc >= 8'(TILES_PER_ROW))
                    begin
                        cur_col_next = '0;
                        cur_row_next = cur_row_reg + 8'd1;
                    end
                    else
                    begin
                        cur_col_next = col_inc;
                    end
                end
                put_cnt_next = put_cnt_reg - DEC_CNT_W'(1);
                if (put_cnt_reg == DEC_CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                rd_next    = ram_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    read_entry_next  = rd_reg;
                    cursor_col_next  = cur_col_reg;
                    cursor_row_next  = cur_row_reg;
                    changed_out_next = changed_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            font_base_reg   <= '0;
            palette_reg     <= '0;
            prio_reg        <= 1'b0;
            put_cnt_reg     <= '0;
            changed_reg     <= 1'b0;
            rd_reg          <= '0;
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            font_base_reg   <= font_base_next;
            palette_reg     <= palette_next;
            prio_reg        <= prio_next;
            put_cnt_reg     <= put_cnt_next;
            changed_reg     <= changed_next;
            rd_reg          <= rd_next;
            cur_col_reg     <= cur_col_next;
            cur_row_reg     <= cur_row_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        char_reg        <= char_next;
        col_reg         <= col_next;
        row_reg         <= row_next;
        w_reg           <= w_next;
        h_reg           <= h_next;
        number_reg      <= number_next;
        rr_reg          <= rr_next;
        cc_reg          <= cc_next;
        read_entry_reg  <= read_entry_next;
        cursor_col_reg  <= cursor_col_next;
        cursor_row_reg  <= cursor_row_next;
        changed_out_reg <= changed_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_entry = read_entry_reg;
    assign cursor_col = cursor_col_reg;
    assign cursor_row = cursor_row_reg;
    assign changed    = changed_out_reg;

    `TTW_ASSERT_IMP(a_write_only_when_busy, ram_we, state_reg == S_FILL || state_reg == S_PUT)
    `TTW_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state_reg != S_IDLE)
    `TTW_ASSERT_IMP(a_result_from_done, $rose(out_valid_reg), $past(state_reg == S_DONE))
    `TTW_ASSERT_IMP(a_put_has_count, state_reg == S_PUT, put_cnt_reg != '0)

endmodule

// ----- tb/sv/text_tilemap_writer_core_tb.sv -----
// self-checking testbench for the text tilemap writer core
module text_tilemap_writer_core_tb;

    import ttw_pkg::*;

    localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
    localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         PHASE_CMDS    = 487;

    typedef struct {
        logic [2:0]  func;
        logic [7:0]  char_code;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [5:0]  rect_width;
        logic [5:0]  rect_height;
        logic [15:0] number;
        logic [3:0]  hex_digits;
        logic [9:0]  read_index;
        bit          drain_first;
    } cmd_t;

    typedef struct packed {
        logic [15:0] read_entry;
        logic [7:0]  cursor_col;
        logic [7:0]  cursor_row;
        logic        changed;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [9:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  func = '0;
    logic [7:0]  char_code = '0;
    logic [7:0]  col = '0;
    logic [7:0]  row = '0;
    logic [5:0]  rect_width = '0;
    logic [5:0]  rect_height = '0;
    logic [15:0] number = '0;
    logic [3:0]  hex_digits = '0;
    logic [9:0]  read_index = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] read_entry;
    logic [7:0]  cursor_col;
    logic [7:0]  cursor_row;
    logic        changed;

    // predictor state
    logic [15:0] tiles [STORE_ENTRIES];
    logic [7:0]  cur_c = '0;
    logic [7:0]  cur_r = '0;
    logic [9:0]  font_base_q = '0;
    logic [2:0]  palette_q = '0;
    logic        prio_q = 1'b0;

    cmd_t    cmd_backlog [$];
    result_t owed_words [$];
    cmd_t    live_cmd;
    int      send_gap_pct = 0;
    int      recv_stall_pct = 0;
    int      n_issued = 0;
    int      n_results = 0;
    int      errors = 0;
    int      op_seen [8] = '{default: 0};

    text_tilemap_writer_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .char_code   (char_code),
        .col         (col),
        .row         (row),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .number      (number),
        .hex_digits  (hex_digits),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_entry  (read_entry),
        .cursor_col  (cursor_col),
        .cursor_row  (cursor_row),
        .changed     (changed)
    );

    always #5 clk = ~clk;

    function automatic logic [15:0] glyph_entry(input logic [7:0] code);
        logic [9:0] tile;
        tile = font_base_q;
        if (code >= CHAR_PRINT_LO && code <= CHAR_PRINT_HI)
        begin
            tile = font_base_q + 10'(code - CHAR_PRINT_LO);
        end
        return {2'b00, prio_q, palette_q, tile};
    endfunction

    function automatic int cell_index(input int r, input int c);
        return (r * TILES_PER_ROW + c) % STORE_ENTRIES;
    endfunction

    // one character at the cursor, returns 1 if a tile was written
    function automatic bit emit_glyph(input logic [7:0] code);
        if (code == CHAR_LF)
        begin
            cur_c = '0;
            cur_r = cur_r + 8'd1;
            return 1'b0;
        end
        if (code == CHAR_CR)
        begin
            cur_c = '0;
            return 1'b0;
        end
        tiles[cell_index(int'(cur_r), int'(cur_c))] = glyph_entry(code);
        cur_c = cur_c + 8'd1;
        if (cur_c >= TILES_PER_ROW)
        begin
            cur_c = '0;
            cur_r = cur_r + 8'd1;
        end
        return 1'b1;
    endfunction

    function automatic result_t advance_tilemap(input cmd_t c);
        result_t    res;
        logic [7:0] digs [DEC_DIGITS];
        logic [3:0] nib;
        int         n;
        int         v;
        int         cnt;
        res = '0;
        case (c.func)
            FUNC_PUT:
            begin
                res.changed = emit_glyph(c.char_code);
            end
            FUNC_SET:
            begin
                cur_c = c.col;
                cur_r = c.row;
            end
            FUNC_FILL:
            begin
                for (int r = 0; r < c.rect_height; r++)
                begin
                    for (int k = 0; k < c.rect_width; k++)
                    begin
                        tiles[cell_index(int'(c.row) + r, int'(c.col) + k)] =
                            glyph_entry(c.char_code);
                    end
                end
                res.changed = (c.rect_width != 0 && c.rect_height != 0);
            end
            FUNC_DEC:
            begin
                n = 0;
                v = c.number;
                do
                begin
                    digs[n] = CHAR_ZERO + 8'(v % 10);
                    v = v / 10;
                    n++;
                end
                while (v != 0 && n < DEC_DIGITS);
                while (n > 0)
                begin
                    n--;
                    if (emit_glyph(digs[n]))
                    begin
                        res.changed = 1'b1;
                    end
                end
            end
            FUNC_HEX:
            begin
                cnt = (c.hex_digits > HEX_MAX) ? HEX_MAX : int'(c.hex_digits);
                for (int i = cnt; i > 0; i--)
                begin
                    nib = 4'(c.number >> (4 * (i - 1)));
                    if (emit_glyph(nib < 10 ? CHAR_ZERO + 8'(nib) : CHAR_UPPER_A + 8'(nib - 10)))
                    begin
                        res.changed = 1'b1;
                    end
                end
            end
            FUNC_READ:
            begin
                res.read_entry = tiles[int'(c.read_index) % STORE_ENTRIES];
            end
            default:
            begin
            end
        endcase
        res.cursor_col = cur_c;
        res.cursor_row = cur_r;
        return res;
    endfunction

    function automatic cmd_t make_cmd(
        input logic [2:0]  f,
        input logic [7:0]  code,
        input logic [7:0]  c,
        input logic [7:0]  r,
        input logic [5:0]  w,
        input logic [5:0]  h,
        input logic [15:0] num,
        input logic [3:0]  dig,
        input logic [9:0]  idx
    );
        cmd_t m;
        m.func        = f;
        m.char_code   = code;
        m.col         = c;
        m.row         = r;
        m.rect_width  = w;
        m.rect_height = h;
        m.number      = num;
        m.hex_digits  = dig;
        m.read_index  = idx;
        m.drain_first = 1'b0;
        return m;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t m;
        int   pick;
        m.func        = 3'($urandom_range(5));
        m.char_code   = 8'($urandom);
        m.col         = 8'($urandom);
        m.row         = 8'($urandom);
        m.rect_width  = 6'($urandom_range(32));
        m.rect_height = 6'($urandom_range(32));
        m.number      = 16'($urandom);
        m.hex_digits  = 4'($urandom);
        m.read_index  = 10'($urandom);
        m.drain_first = ($urandom_range(99) == 0);
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            m.func = FUNC_PUT;
            case ($urandom_range(9))
                0: m.char_code = CHAR_LF;
                1: m.char_code = CHAR_CR;
                2: ;
                default: m.char_code = 8'($urandom_range(CHAR_PRINT_HI, CHAR_PRINT_LO));
            endcase
        end
        else if (pick < 50)
        begin
            m.func = FUNC_SET;
            if ($urandom_range(3) != 0)
            begin
                m.col = 8'($urandom_range(TILES_PER_ROW - 1));
            end
        end
        else if (pick < 60)
        begin
            m.func = FUNC_FILL;
            // mostly small rectangles, now and then up to the full map
            if ($urandom_range(49) != 0)
            begin
                m.rect_width  = 6'($urandom_range(4));
                m.rect_height = 6'($urandom_range(4));
            end
        end
        else if (pick < 68)
        begin
            m.func = FUNC_DEC;
            m.number = m.number >> $urandom_range(15);
        end
        else if (pick < 76)
        begin
            m.func = FUNC_HEX;
        end
        else if (pick < 96)
        begin
            m.func = FUNC_READ;
        end
        else
        begin
            m.func = ($urandom_range(1) == 0) ? FUNC_SPARE_LO : FUNC_SPARE_HI;
        end
        return m;
    endfunction

    task automatic issue(input cmd_t m);
        cmd_backlog.push_back(m);
        n_issued++;
    endtask

    task automatic wait_idle();
        while (n_results != n_issued)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FONT_BASE: font_base_q = val;
            CFG_PALETTE:   palette_q   = val[2:0];
            CFG_PRIORITY:  prio_q      = val[0];
            default: ;
        endcase
    endtask

    task automatic setup_regs(input logic [9:0] font, input logic [2:0] pal, input logic prio);
        wait_idle();
        write_reg(CFG_FONT_BASE, font);
        write_reg(CFG_PALETTE, 10'(pal));
        write_reg(CFG_PRIORITY, 10'(prio));
    endtask

    always @(posedge clk)
    begin : cmd_driver
        cmd_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                owed_words.push_back(advance_tilemap(live_cmd));
                op_seen[live_cmd.func]++;
            end
            if (!in_valid || !in_stall)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct
                    && !(cmd_backlog[0].drain_first && owed_words.size() != 0))
                begin
                    nxt = cmd_backlog.pop_front();
                    live_cmd    <= nxt;
                    in_valid    <= 1'b1;
                    func        <= nxt.func;
                    char_code   <= nxt.char_code;
                    col         <= nxt.col;
                    row         <= nxt.row;
                    rect_width  <= nxt.rect_width;
                    rect_height <= nxt.rect_height;
                    number      <= nxt.number;
                    hex_digits  <= nxt.hex_digits;
                    read_index  <= nxt.read_index;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {read_entry, cursor_col, cursor_row, changed};
                if (owed_words.size() == 0)
                begin
                    $display("%0t: unexpected result word entry=%h col=%0d row=%0d changed=%0d",
                             $time, got.read_entry, got.cursor_col, got.cursor_row, got.changed);
                    errors++;
                end
                else
                begin
                    want = owed_words.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch, expected entry=%h col=%0d row=%0d changed=%0d,",
                                 $time, want.read_entry, want.cursor_col, want.cursor_row,
                                 want.changed);
                        $display("%0t:           got entry=%h col=%0d row=%0d changed=%0d",
                                 $time, got.read_entry, got.cursor_col, got.cursor_row,
                                 got.changed);
                        errors++;
                    end
                end
                n_results++;
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin : stimulus
        cmd_t m;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        setup_regs(10'd0, 3'd0, 1'b0);

        // whole store first so that every later read hits a written entry
        issue(make_cmd(FUNC_FILL, CHAR_PRINT_HI, 8'd0, 8'd0, 6'd32, 6'd32, 16'd0, 4'd0, 10'd0));
        issue(make_cmd(FUNC_READ, 8'd0, 8'd0, 8'd0, 6'd0, 6'd0, 16'd0, 4'd0, 10'd0));
        issue(make_cmd(FUNC_READ, 8'd0, 8'd0, 8'd0, 6'd0, 6'd0, 16'd0, 4'd0, 10'd1023));
        issue(make_cmd(FUNC_PUT, CHAR_PRINT_LO, 8'd0, 8'd0, 6'd0, 6'd0, 16'd0, 4'd0, 10'd0));
        issue(make_cmd(FUNC_PUT, 8'd0, 8'd0, 8'd0, 6'd0, 6'd0, 16'd0, 4'd0, 10'd0));
        issue(make_cmd(FUNC_PUT, 8'd255, 8'd0, 8'd0, 6'd0, 6'd0, 16'd0, 4'd0, 10'd0));
        issue(make_cmd(FUNC_PUT, CHAR_LF, 8'd0, 8'd0, 6'd0, 6'd0, 16'd0, 4'd0, 10'd0));
        issue(make_cmd(FUNC_PUT, CHAR_CR, 8'd0, 8'd0, 6'd0, 6'd0, 16'd0, 4'd0, 10'd0));
        // right edge wraps to the next row
        issue(make_cmd(FUNC_SET, 8'd0, 8'd31, 8'd0, 6'd0, 6'd0, 16'd0, 4'd0, 10'd0));
        issue(make_cmd(FUNC_PUT, 8'd90, 8'd0, 8'd0, 6'd0, 6'd0, 16'd0, 4'd0, 10'd0));
        // column 255 wraps to 0 without a new row
        issue(make_cmd(FUNC_SET, 8'd0, 8'd255, 8'd3, 6'd0, 6'd0, 16'd0, 4'd0, 10'd0));
        issue(make_cmd(FUNC_PUT, 8'd120, 8'd0, 8'd0, 6'd0, 6'd0, 16'd0, 4'd0, 10'd0));
        // row wraps at 256
        issue(make_cmd(FUNC_SET, 8'd0, 8'd5, 8'd255, 6'd0, 6'd0, 16'd0, 4'd0, 10'd0));
        issue(make_cmd(FUNC_PUT, CHAR_LF, 8'd0, 8'd0, 6'd0, 6'd0, 16'd0, 4'd0, 10'd0));
        // empty rectangles, then one past the right edge and past the store end
        issue(make_cmd(FUNC_FILL, 8'd65, 8'd2, 8'd2, 6'd0, 6'd5, 16'd0, 4'd0, 10'd0));
        issue(make_cmd(FUNC_FILL, 8'd65, 8'd2, 8'd2, 6'd5, 6'd0, 16'd0, 4'd0, 10'd0));
        issue(make_cmd(FUNC_FILL, 8'd31, 8'd30, 8'd255, 6'd4, 6'd2, 16'd0, 4'd0, 10'd0));
        issue(make_cmd(FUNC_DEC, 8'd0, 8'd0, 8'd0, 6'd0, 6'd0, 16'd0, 4'd0, 10'd0));
        issue(make_cmd(FUNC_DEC, 8'd0, 8'd0, 8'd0, 6'd0, 6'd0, 16'd65535, 4'd0, 10'd0));
        issue(make_cmd(FUNC_DEC, 8'd0, 8'd0, 8'd0, 6'd0, 6'd0, 16'd1000, 4'd0, 10'd0));
        issue(make_cmd(FUNC_HEX, 8'd0, 8'd0, 8'd0, 6'd0, 6'd0, 16'hBEEF, 4'd0, 10'd0));
        issue(make_cmd(FUNC_HEX, 8'd0, 8'd0, 8'd0, 6'd0, 6'd0, 16'hBEEF, 4'd4, 10'd0));
        issue(make_cmd(FUNC_HEX, 8'd0, 8'd0, 8'd0, 6'd0, 6'd0, 16'hA5C3, 4'd15, 10'd0));
        issue(make_cmd(FUNC_HEX, 8'd0, 8'd0, 8'd0, 6'd0, 6'd0, 16'h0009, 4'd1, 10'd0));
        issue(make_cmd(FUNC_SPARE_LO, 8'd255, 8'd255, 8'd255, 6'd32, 6'd32, 16'hFFFF,
                       4'd15, 10'd1023));
        issue(make_cmd(FUNC_SPARE_HI, 8'd65, 8'd1, 8'd1, 6'd1, 6'd1, 16'd1, 4'd1, 10'd1));
        issue(make_cmd(FUNC_READ, 8'd0, 8'd0, 8'd0, 6'd0, 6'd0, 16'd0, 4'd0, 10'd5));

        for (int p = 1; p <= 4; p++)
        begin
            case (p)
                1: setup_regs(10'd928, 3'd7, 1'b1);
                2: setup_regs(10'($urandom_range(928)), 3'($urandom), 1'b0);
                3: setup_regs(10'($urandom_range(928)), 3'($urandom), 1'b1);
                default: setup_regs(10'($urandom_range(928)), 3'd3, 1'($urandom));
            endcase
            send_gap_pct   = (p == 1) ? 74 : (p == 3) ? 7 : 0;
            recv_stall_pct = (p == 2) ? 74 : (p == 3) ? 7 : 0;
            for (int k = 0; k < PHASE_CMDS; k++)
            begin
                m = random_cmd();
                if (k == 100)
                begin
                    m.drain_first = 1'b1;
                end
                issue(m);
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (owed_words.size() != 0)
        begin
            $display("%0t: %0d expected result words never arrived", $time, owed_words.size());
            errors++;
        end
        $display("commands: %0d put, %0d cursor set, %0d fill, %0d decimal, %0d hex, %0d read,",
                 op_seen[FUNC_PUT], op_seen[FUNC_SET], op_seen[FUNC_FILL], op_seen[FUNC_DEC],
                 op_seen[FUNC_HEX], op_seen[FUNC_READ]);
        $display("%0d spare codes; %0d result words checked over 5 register settings",
                 op_seen[FUNC_SPARE_LO] + op_seen[FUNC_SPARE_HI], n_results);
        if (errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin : watchdog
        #20000000;
        $display("%0t: timed out with %0d of %0d result words", $time, n_results, n_issued);
        $display("TEST FAILED");
        $finish;
    end

endmodule
